// File: sv/sha1_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
// No dependencies; the top level and the testbench import this package.
package sha1_pkg;

    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned WINDOW_WORDS = 16;
    localparam int unsigned ROUNDS = 80;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_POS = 56;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  word_index;
        logic [31:0] digest_word;
        logic        last_word;
    } t_out_word;

endpackage

// File: sv/sha1_stream_if.sv
// Valid/ready channel that carries one word of the given payload type.
// Depends on nothing; the payload types come from sha1_pkg.
interface sha1_stream_if #(
    parameter type t_word = logic [7:0]
);
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/sha1_message_digest.sv
// SHA-1 message digest: byte-wide input, five 32-bit digest words out.
// Depends on sha1_pkg and on sha1_stream_if for both channels.

// Each input word, with or without a byte, is taken while the block is idle. The
// 64th byte of a block stalls the input for the 80 rounds through one shared round
// adder, one per cycle, and an add step that adds the round result into the chain
// value. A word with last set starts the padding, which shifts one pad or length
// byte per cycle into the block until it is full (with an extra block when 56 or
// more bytes were already in the block), each full block again going through the
// rounds and the add step. The five digest words then leave one per
// accepted output word, after which a new message may start.
module sha1_message_digest
    import sha1_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1_stream_if.sink   i_in,
    sha1_stream_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state       r_state;
    logic [31:0]  r_h [DIGEST_WORDS];
    logic [31:0]  r_v [DIGEST_WORDS];
    logic [31:0]  r_w [WINDOW_WORDS];
    logic [60:0]  r_msg;
    logic [5:0]   r_fill;
    logic [6:0]   r_t;
    logic [63:0]  r_len;
    logic [2:0]   r_oi;
    logic         r_fin;
    logic         r_pad_first;
    logic         r_len_ok;
    logic         r_pad_done;

    logic         n_in_acc;
    logic         n_out_acc;
    logic [7:0]   n_pad_byte;
    logic [31:0]  n_wsel;
    logic [31:0]  n_wx;
    logic [31:0]  n_f;
    logic [31:0]  n_k;
    logic [31:0]  n_tmp;

    assign n_in_acc  = i_in.valid && i_in.ready;
    assign n_out_acc = o_out.valid && o_out.ready;

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data.word_index = r_oi;
    assign o_out.data.digest_word = r_h[0];
    assign o_out.data.last_word = (r_oi == 3'(DIGEST_WORDS - 1));

    always_comb begin
        if (r_pad_first) begin
            n_pad_byte = PAD_BYTE;
        end else if (r_len_ok && (r_fill >= 6'(LEN_POS))) begin
            n_pad_byte = r_len[63:56];
        end else begin
            n_pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_wx = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        if (r_t < 7'd16) begin
            n_wsel = r_w[0];
        end else begin
            n_wsel = {n_wx[30:0], n_wx[31]};
        end
        if (r_t < 7'd20) begin
            n_f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            n_k = K0;
        end else if (r_t < 7'd40) begin
            n_f = r_v[1] ^ r_v[2] ^ r_v[3];
            n_k = K1;
        end else if (r_t < 7'd60) begin
            n_f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            n_k = K2;
        end else begin
            n_f = r_v[1] ^ r_v[2] ^ r_v[3];
            n_k = K3;
        end
        n_tmp = {r_v[0][26:0], r_v[0][31:27]} + n_f + r_v[4] + n_k + n_wsel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_h         <= H_INIT;
            r_msg       <= '0;
            r_fill      <= '0;
            r_t         <= '0;
            r_oi        <= '0;
            r_fin       <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_pad_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        if (i_in.data.has_byte) begin
                            for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
                                r_w[i] <= {r_w[i][23:0], r_w[i + 1][31:24]};
                            end
                            r_w[WINDOW_WORDS - 1] <= {r_w[WINDOW_WORDS - 1][23:0],
                                                      i_in.data.data_byte};
                            r_msg  <= r_msg + 61'd1;
                            r_fill <= r_fill + 6'd1;
                        end
                        if (i_in.data.last) begin
                            r_fin       <= 1'b1;
                            r_pad_first <= 1'b1;
                            r_len_ok    <= 1'b0;
                            r_pad_done  <= 1'b0;
                        end
                        if (i_in.data.has_byte && (r_fill == 6'(BLOCK_BYTES - 1))) begin
                            r_v     <= r_h;
                            r_t     <= '0;
                            r_state <= S_ROUND;
                        end else if (i_in.data.last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
                        r_w[i] <= {r_w[i][23:0], r_w[i + 1][31:24]};
                    end
                    r_w[WINDOW_WORDS - 1] <= {r_w[WINDOW_WORDS - 1][23:0], n_pad_byte};
                    r_fill <= r_fill + 6'd1;
                    if (r_pad_first) begin
                        r_pad_first <= 1'b0;
                        r_len       <= {r_msg, 3'b000};
                        r_len_ok    <= (r_fill < 6'(LEN_POS));
                    end else if (r_len_ok && (r_fill >= 6'(LEN_POS))) begin
                        r_len <= {r_len[55:0], 8'h00};
                    end
                    if (r_fill == 6'(BLOCK_BYTES - 1)) begin
                        r_pad_done <= r_len_ok && !r_pad_first;
                        r_v        <= r_h;
                        r_t        <= '0;
                        r_state    <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_v[0] <= n_tmp;
                    r_v[1] <= r_v[0];
                    r_v[2] <= {r_v[1][1:0], r_v[1][31:2]};
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3];
                    for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
                        r_w[i] <= r_w[i + 1];
                    end
                    r_w[WINDOW_WORDS - 1] <= n_wsel;
                    r_t <= r_t + 7'd1;
                    if (r_t == 7'(ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < DIGEST_WORDS; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_pad_done) begin
                        r_oi    <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_len_ok <= 1'b1;
                        r_state  <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (n_out_acc) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'(DIGEST_WORDS - 1)) begin
                            r_h        <= H_INIT;
                            r_msg      <= '0;
                            r_fill     <= '0;
                            r_fin      <= 1'b0;
                            r_pad_done <= 1'b0;
                            r_state    <= S_IDLE;
                        end else begin
                            for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                                r_h[i] <= r_h[i + 1];
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/sha1_message_digest_tb.sv
// Self-checking testbench for sha1_message_digest: feeds byte messages and compares the
// digest words against a SHA-1 predictor kept in the testbench or known empty/abc digests.
// Depends on sha1_pkg, sha1_stream_if and the sha1_message_digest RTL.
module sha1_message_digest_tb;
    import sha1_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS = 240;
    localparam int CALM_AFTER = 230;
    localparam int DIG_NONE = -1;
    localparam int DIG_EMPTY = 0;
    localparam int DIG_ABC = 1;

    localparam logic [159:0] KNOWN_DIGEST [2] = '{
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709,
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d
    };

    localparam int BOUNDARY_LEN [4] = '{63, 56, 64, 55};

    typedef struct {
        logic [7:0] byte_val;
        bit         has;
        bit         fin;
        int         known;
    } t_row;

    localparam int STIM_ROWS = 12;

    t_row stim_tab [STIM_ROWS] = '{
        '{8'hFF, 1'b0, 1'b0, DIG_NONE},
        '{8'h00, 1'b0, 1'b1, DIG_EMPTY},
        '{8'h61, 1'b1, 1'b0, DIG_NONE},
        '{8'h62, 1'b1, 1'b0, DIG_NONE},
        '{8'h63, 1'b1, 1'b1, DIG_ABC},
        '{8'h00, 1'b1, 1'b0, DIG_NONE},
        '{8'hFF, 1'b1, 1'b1, DIG_NONE},
        '{8'h5A, 1'b1, 1'b0, DIG_NONE},
        '{8'hA5, 1'b0, 1'b0, DIG_NONE},
        '{8'h3C, 1'b0, 1'b1, DIG_NONE},
        '{8'h80, 1'b1, 1'b1, DIG_NONE},
        '{8'hC3, 1'b0, 1'b1, DIG_EMPTY}
    };

    logic i_clk;
    logic i_rst_n;

    sha1_stream_if #(.t_word(t_in_word))  in_if ();
    sha1_stream_if #(.t_word(t_out_word)) out_if ();

    sha1_message_digest dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    logic [31:0] hash_h [DIGEST_WORDS];
    logic [31:0] blk_w [WINDOW_WORDS];
    logic [60:0] msg_len;
    t_out_word   digest_q [$];
    int          errors;
    int          idle_cycles;
    bit          calm;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha_reset();
        for (int i = 0; i < DIGEST_WORDS; i++) hash_h[i] = H_INIT[i];
        for (int i = 0; i < WINDOW_WORDS; i++) blk_w[i] = '0;
        msg_len = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] wv [WINDOW_WORDS];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int i = 0; i < WINDOW_WORDS; i++) wv[i] = blk_w[i];
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int t = 0; t < ROUNDS; t++) begin
            if (t >= 16) begin
                wv[t % 16] = rol(wv[(t + 13) % 16] ^ wv[(t + 8) % 16]
                                 ^ wv[(t + 2) % 16] ^ wv[t % 16], 1);
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            tmp = rol(a, 5) + f + e + k + wv[t % 16];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = tmp;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    function automatic void sha_place(input logic [5:0] pos, input logic [7:0] b);
        int sh;
        sh = 24 - 8 * int'(pos[1:0]);
        if (pos[1:0] == 2'd0) blk_w[pos[5:2]] = 32'(b) << sh;
        else blk_w[pos[5:2]] |= 32'(b) << sh;
    endfunction

    // Returns 1 when the word closes a message; dig then holds the final hash.
    function automatic bit sha_take(input t_in_word w, output logic [159:0] dig);
        logic [5:0]  pos;
        logic [63:0] nbits;
        dig = '0;
        if (w.has_byte) begin
            pos = msg_len[5:0];
            sha_place(pos, w.data_byte);
            msg_len = msg_len + 61'd1;
            if (pos == 6'd63) sha_compress();
        end
        if (!w.last) return 1'b0;
        pos = msg_len[5:0];
        sha_place(pos, PAD_BYTE);
        for (int i = int'(pos[5:2]) + 1; i < WINDOW_WORDS; i++) blk_w[i] = '0;
        if (pos >= LEN_POS) begin
            sha_compress();
            for (int i = 0; i < 14; i++) blk_w[i] = '0;
        end
        nbits = {msg_len, 3'b000};
        blk_w[14] = nbits[63:32];
        blk_w[15] = nbits[31:0];
        sha_compress();
        dig = {hash_h[0], hash_h[1], hash_h[2], hash_h[3], hash_h[4]};
        sha_reset();
        return 1'b1;
    endfunction

    task automatic push_word(input t_in_word w, input int known);
        logic [159:0] dig;
        t_out_word    ow;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= w;
        do @(posedge i_clk); while (!in_if.ready);
        if (sha_take(w, dig)) begin
            if (known != DIG_NONE) dig = KNOWN_DIGEST[known];
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                ow.word_index = 3'(i);
                ow.digest_word = dig[159 - 32 * i -: 32];
                ow.last_word = (i == DIGEST_WORDS - 1);
                digest_q.push_back(ow);
            end
        end
    endtask

    task automatic drain_digests();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : sink_side
        out_if.ready <= 1'b0;
        repeat (10) @(posedge i_clk);
        forever begin
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : digest_check
        t_out_word exp_w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: digest word with none pending: %h", $time, out_if.data);
                errors++;
            end else begin
                exp_w = digest_q.pop_front();
                if (out_if.data.word_index !== exp_w.word_index) begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             exp_w.word_index, out_if.data.word_index);
                    errors++;
                end
                if (out_if.data.digest_word !== exp_w.digest_word) begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             exp_w.digest_word, out_if.data.digest_word);
                    errors++;
                end
                if (out_if.data.last_word !== exp_w.last_word) begin
                    $display("%0t: last_word expected %0b actual %0b", $time,
                             exp_w.last_word, out_if.data.last_word);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_word w;
        int       sent;
        int       msg;
        int       len;
        bit       with_byte;
        errors = 0;
        idle_cycles = 0;
        calm = 1'b0;
        sha_reset();
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < STIM_ROWS; r++) begin
            w.data_byte = stim_tab[r].byte_val;
            w.has_byte = stim_tab[r].has;
            w.last = stim_tab[r].fin;
            push_word(w, stim_tab[r].known);
        end

        // The sender holds off here until every digest word has come back.
        drain_digests();

        sent = 0;
        msg = 0;
        while (sent < RANDOM_WORDS || msg < 5) begin
            if (msg < 4) begin
                len = BOUNDARY_LEN[msg];
            end else begin
                case ($urandom_range(0, 7))
                    0: len = $urandom_range(56, 72);
                    1: len = 0;
                    default: len = $urandom_range(1, 20);
                endcase
            end
            with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    w.data_byte = 8'($urandom);
                    w.has_byte = 1'b0;
                    w.last = 1'b0;
                    push_word(w, DIG_NONE);
                end
                w.data_byte = 8'($urandom);
                w.has_byte = 1'b1;
                w.last = with_byte && (i == len - 1);
                push_word(w, DIG_NONE);
                sent++;
            end
            if (!with_byte) begin
                w.data_byte = 8'($urandom);
                w.has_byte = 1'b0;
                w.last = 1'b1;
                push_word(w, DIG_NONE);
                sent++;
            end
            msg++;
            if (sent >= CALM_AFTER) calm = 1'b1;
        end

        drain_digests();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
